// ===== design/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants of the tagged chunk scanner: scan phases,
// result codes, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // Default upper bound on a descriptor length byte
  localparam int unsigned MaxDescriptorLenDef = 64;
  // Longest tag the configuration can hold
  localparam int unsigned MaxTagLen = 24;
  // Tag length after reset
  localparam logic [4:0] TagLenReset = 5'd4;

  // File magic "trrn", first byte first
  localparam logic [7:0] Magic [4] = '{8'h74, 8'h72, 8'h72, 8'h6E};
  // Accepted version byte range
  localparam logic [7:0] VersionMin = 8'd7;
  localparam logic [7:0] VersionMax = 8'd12;

  // Result record width and its tdata width rounded up to bytes
  localparam int unsigned ResultW = 3 + 32 + 32;
  localparam int unsigned ResultTdataW = ((ResultW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_DESC   = 3'd2,
    PH_BLEN   = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5
  } tcs_phase_e;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_DESC    = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } tcs_status_e;

  typedef enum logic [1:0] {
    CFG_TAG_LENGTH = 2'd0,
    CFG_TAG_FIRST  = 2'd1,
    CFG_TAG_MIDDLE = 2'd2,
    CFG_TAG_LAST   = 2'd3
  } tcs_cfg_e;

  typedef struct packed {
    logic [31:0] data_length;
    logic [31:0] data_offset;
    logic [2:0]  scan_status;
  } tcs_result_t;

endpackage

// ===== design/tcs_out_buf.sv =====
// ----------------------------------------------------------------------------
// tcs_out_buf
// Two-entry result buffer: an output register and a skid register, so the
// scanner keeps taking bytes while a result waits on the output stream.
// ----------------------------------------------------------------------------
module tcs_out_buf import tcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tcs_result_t push_data_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        ready_i,
  output tcs_result_t data_o
);

  logic        out_vld_q, out_vld_d;
  logic        skid_vld_q, skid_vld_d;
  tcs_result_t out_q, out_d;
  tcs_result_t skid_q, skid_d;
  logic        pop;

  assign pop = out_vld_q && ready_i;

  // Refill the output register from skid, then from a new request
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else if (push_i) begin
        out_d     = push_data_i;
        out_vld_d = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (push_i) begin
      skid_d     = push_data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

  // Skid entry never holds a result while the output register is empty
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty output register");

  // A drained output register takes the waiting skid result next
  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ready_i && skid_vld_q) |=> (out_vld_q && out_q == $past(skid_q)))
    else $error("skid result lost on drain");

  // A request into an empty buffer is registered straight into the output entry
  a_push_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !out_vld_q) |=> (out_vld_q && out_q == $past(push_data_i)))
    else $error("request into empty buffer not presented");

  // No request arrives while both entries are taken
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("request while buffer full");

endmodule

// ===== design/tagged_chunk_scanner_core.sv =====
// ----------------------------------------------------------------------------
// tagged_chunk_scanner_core
// Streams a tagged chunk file one byte per request and reports where the
// record whose descriptor equals the configured tag keeps its data.
// ----------------------------------------------------------------------------
// The scanner takes one file byte per clock cycle: each accepted byte updates
// the registered scan state through compare and counter logic, and any
// result lands in a two-entry output buffer, so s_axis_tready stays high
// except while two results wait unread on the output stream. At most one
// result comes per file; after it, bytes are dropped until a byte marked in
// tuser as the start of a new file. Tag registers may be rewritten between
// files; the configuration port is always ready.
module tagged_chunk_scanner_core import tcs_pkg::*; #(
  parameter int unsigned MAX_DESCRIPTOR_LEN = MaxDescriptorLenDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [63:0]             cfg_data_i,
  // file byte stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] file_byte
  input  logic                    s_axis_tuser,   // [0] first_byte
  input  logic                    s_axis_tlast,   // final_byte
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [ResultTdataW-1:0] m_axis_tdata    // [2:0] scan_status,
                                                  // [34:3] data_offset,
                                                  // [66:35] data_length
);

  localparam int unsigned DescW = $clog2(MAX_DESCRIPTOR_LEN + 1);
  localparam int unsigned IdxW  = (DescW > 5) ? DescW : 5;

  // Configuration registers
  logic [4:0]    tag_len_q;
  logic [191:0]  tag_chars_q;
  logic [4:0]    tag_len_eff;

  // Scan state
  tcs_phase_e        phase_q, phase_d;
  logic [31:0]       pos_q, pos_d;
  logic [31:0]       rem_q, rem_d;
  logic [DescW-1:0]  size_q, size_d;
  logic [DescW-1:0]  idx_q, idx_d;
  logic              match_q, match_d;
  logic              zero_q, zero_d;
  logic [31:0]       acc_q, acc_d;

  logic              in_acc;
  logic              buf_full;
  logic              emit;
  tcs_result_t       res;
  tcs_result_t       out_res;
  logic [31:0]       pos_cur;
  logic [31:0]       acc_new;

  // Tag character at a descriptor index, zero past the tag storage
  function automatic logic [7:0] tag_at(logic [191:0] chars, logic [DescW-1:0] i);
    logic [IdxW-1:0] wi;
    wi = IdxW'(i);
    if (wi < IdxW'(MaxTagLen)) return chars[wi[4:0]*8 +: 8];
    return 8'd0;
  endfunction

  // True where the tag string ends exactly at index i
  function automatic logic tag_ends(logic [191:0] chars, logic [4:0] tlen,
                                    logic [DescW-1:0] i);
    return (IdxW'(i) >= IdxW'(tlen)) || (tag_at(chars, i) == 8'd0);
  endfunction

  assign tag_len_eff = (tag_len_q > 5'(MaxTagLen)) ? 5'(MaxTagLen) : tag_len_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_len_q   <= TagLenReset;
      tag_chars_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TAG_LENGTH: tag_len_q            <= cfg_data_i[4:0];
        CFG_TAG_FIRST:  tag_chars_q[63:0]    <= cfg_data_i;
        CFG_TAG_MIDDLE: tag_chars_q[127:64]  <= cfg_data_i;
        CFG_TAG_LAST:   tag_chars_q[191:128] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !buf_full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Advance the scan by one byte
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    size_d  = size_q;
    idx_d   = idx_q;
    match_d = match_q;
    zero_d  = zero_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    res     = '0;
    pos_cur = '0;
    acc_new = '0;
    if (in_acc) begin
      // restart on the first byte of a file
      if (s_axis_tuser) begin
        phase_d = PH_HEADER;
        pos_d   = '0;
        rem_d   = '0;
        size_d  = '0;
        idx_d   = '0;
        match_d = 1'b1;
        zero_d  = 1'b0;
        acc_d   = '0;
      end
      if (phase_d != PH_DONE) begin
        pos_cur = pos_d;
        pos_d   = pos_d + 32'd1;
        unique case (phase_d)
          PH_HEADER: begin
            if (pos_cur < 32'd4) begin
              if (s_axis_tdata != Magic[pos_cur[1:0]] || s_axis_tlast) begin
                emit = 1'b1;
                res.scan_status = ST_BAD_MAGIC;
              end
            end else if (s_axis_tdata < VersionMin || s_axis_tdata > VersionMax) begin
              emit = 1'b1;
              res.scan_status = ST_BAD_VERSION;
            end else if (s_axis_tlast) begin
              emit = 1'b1;
              res.scan_status = ST_NOT_FOUND;
            end else begin
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (s_axis_tlast) begin
              emit = 1'b1;
              res.scan_status = ST_NOT_FOUND;
            end else if (s_axis_tdata == 8'd0 ||
                         32'(s_axis_tdata) > 32'(MAX_DESCRIPTOR_LEN)) begin
              emit = 1'b1;
              res.scan_status = ST_BAD_DESC;
            end else begin
              size_d  = DescW'(s_axis_tdata);
              idx_d   = '0;
              match_d = 1'b1;
              zero_d  = 1'b0;
              phase_d = PH_DESC;
            end
          end
          PH_DESC: begin
            if (s_axis_tlast) begin
              emit = 1'b1;
              res.scan_status = ST_NOT_FOUND;
            end else begin
              // compare up to the first zero byte of the descriptor
              if (!zero_d) begin
                if (s_axis_tdata == 8'd0) begin
                  zero_d = 1'b1;
                  if (!tag_ends(tag_chars_q, tag_len_eff, idx_d)) match_d = 1'b0;
                end else if (IdxW'(idx_d) >= IdxW'(tag_len_eff) ||
                             tag_at(tag_chars_q, idx_d) != s_axis_tdata) begin
                  match_d = 1'b0;
                end
              end
              idx_d = idx_d + DescW'(1);
              if (idx_d >= size_d) begin
                if (!zero_d && !tag_ends(tag_chars_q, tag_len_eff, size_d))
                  match_d = 1'b0;
                idx_d   = '0;
                acc_d   = '0;
                phase_d = PH_BLEN;
              end
            end
          end
          PH_BLEN: begin
            if (s_axis_tlast) begin
              emit = 1'b1;
              res.scan_status = ST_NOT_FOUND;
            end else begin
              // little-endian block length
              acc_new = acc_d | (32'(s_axis_tdata) << {idx_d[1:0], 3'b000});
              acc_d   = acc_new;
              if (idx_d[1:0] != 2'd3) begin
                idx_d = idx_d + DescW'(1);
              end else begin
                idx_d = '0;
                if (match_d) begin
                  emit = 1'b1;
                  res.scan_status = ST_FOUND;
                  res.data_offset = pos_d;
                  res.data_length = acc_new;
                end else begin
                  rem_d   = acc_new;
                  phase_d = (acc_new == 32'd0) ? PH_LEN : PH_SKIP;
                end
              end
            end
          end
          PH_SKIP: begin
            if (s_axis_tlast) begin
              emit = 1'b1;
              res.scan_status = ST_NOT_FOUND;
            end else begin
              rem_d = rem_d - 32'd1;
              if (rem_d == 32'd0) phase_d = PH_LEN;
            end
          end
          default: phase_d = PH_DONE;
        endcase
        if (emit) phase_d = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      rem_q   <= '0;
      size_q  <= '0;
      idx_q   <= '0;
      match_q <= 1'b1;
      zero_q  <= 1'b0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      size_q  <= size_d;
      idx_q   <= idx_d;
      match_q <= match_d;
      zero_q  <= zero_d;
      acc_q   <= acc_d;
    end
  end

  // Hold results until the output stream takes them
  tcs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = ResultTdataW'(out_res);

  // Every result closes the scan
  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> (phase_q == PH_DONE))
    else $error("scan still running after a result");

  // Block length field takes exactly four bytes
  a_blen_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BLEN) |-> (idx_q < DescW'(4)))
    else $error("block length byte index out of range");

  // Descriptor walk stays inside the announced length
  a_desc_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DESC) |-> (size_q != '0 && idx_q < size_q))
    else $error("descriptor index beyond descriptor length");

endmodule

// ===== sim/tagged_chunk_scanner_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tagged_chunk_scanner_core_test
// Self-checking bench for the tagged chunk scanner. A short table of directed
// bytes opens the run, then random files follow: well-formed record chains
// with random content, truncated and corrupted files and loose noise. The tag
// registers change between groups of files. Every result request is checked
// field by field against an in-bench model of the scan.
// ----------------------------------------------------------------------------
module tagged_chunk_scanner_core_test;
  import tcs_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;

  // record kinds for the file builder
  localparam int unsigned RecMatch = 0;
  localparam int unsigned RecNear = 1;
  localparam int unsigned RecRandom = 2;
  localparam int unsigned RecLong = 3;

  typedef struct packed {
    logic [7:0]  data;
    bit          head;
    bit          tail;
    bit          typed;
    tcs_status_e status;
    logic [31:0] offset;
    logic [31:0] length;
  } probe_t;

  // directed bytes; typed rows carry their result, the rest use the model
  localparam probe_t Probes [25] = '{
    // magic cut short by the final byte
    '{8'h74, 1'b1, 1'b1, 1'b1, ST_BAD_MAGIC, 32'd0, 32'd0},
    // wrong first magic byte
    '{8'h00, 1'b1, 1'b0, 1'b1, ST_BAD_MAGIC, 32'd0, 32'd0},
    // version above range on the final byte
    '{8'h74, 1'b1, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h6E, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h0D, 1'b0, 1'b1, 1'b1, ST_BAD_VERSION, 32'd0, 32'd0},
    // descriptor length just above the limit
    '{8'h74, 1'b1, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h6E, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h0C, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h41, 1'b0, 1'b0, 1'b1, ST_BAD_DESC, 32'd0, 32'd0},
    // empty descriptor matches the empty reset tag, all-ones block length
    '{8'h74, 1'b1, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h72, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h6E, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h07, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, ST_FOUND, 32'd11, 32'hFFFF_FFFF},
    // dropped after a result
    '{8'hAA, 1'b0, 1'b0, 1'b0, ST_FOUND, 32'd0, 32'd0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [1:0]              cfg_index_i;
  logic [63:0]             cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata;   // [7:0] file_byte
  logic                    s_axis_tuser;   // [0] first_byte
  logic                    s_axis_tlast;   // final_byte
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [ResultTdataW-1:0] m_axis_tdata;   // [2:0] scan_status, [34:3] data_offset,
                                           // [66:35] data_length

  // model copy of the tag registers
  logic [4:0]  tag_len_q;
  logic [63:0] tag_words [3];
  logic [7:0]  tag_text [$];

  // model copy of the scan state
  tcs_phase_e  sc_phase;
  logic [31:0] sc_pos;
  logic [31:0] sc_skip;
  logic [6:0]  sc_desc_len;
  logic [6:0]  sc_idx;
  bit          sc_hit;
  bit          sc_nul;
  logic [31:0] sc_blen;

  tcs_result_t pending_reports [$];
  logic [7:0]  doc [$];
  tcs_result_t seen_report;
  tcs_result_t want_report;

  int unsigned live_items;
  int unsigned faults;
  int unsigned idle_cycles;
  bit          steady;
  bit          hold_out;

  tagged_chunk_scanner_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scan model
  // ---------------------------------------------------------------------------
  function automatic int unsigned tag_span();
    return (tag_len_q > MaxTagLen) ? MaxTagLen : int'(tag_len_q);
  endfunction

  function automatic logic [7:0] tag_byte(int unsigned i);
    if (i >= MaxTagLen) return 8'h00;
    return tag_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // true when the tag string ends exactly at position i
  function automatic bit tag_stops(int unsigned i);
    return i >= tag_span() || tag_byte(i) == 8'h00;
  endfunction

  function automatic void restart_scan();
    sc_phase    = PH_HEADER;
    sc_pos      = '0;
    sc_skip     = '0;
    sc_desc_len = '0;
    sc_idx      = '0;
    sc_hit      = 1'b1;
    sc_nul      = 1'b0;
    sc_blen     = '0;
  endfunction

  function automatic tcs_result_t close_scan(tcs_status_e st, logic [31:0] off,
                                             logic [31:0] len);
    tcs_result_t r;
    r.scan_status = st;
    r.data_offset = off;
    r.data_length = len;
    sc_phase = PH_DONE;
    return r;
  endfunction

  // advance the scan by one byte; returns 1 when the byte ends the scan
  function automatic bit predict_scan(input logic [7:0] b, input bit head, input bit tail,
                                      output tcs_result_t res);
    logic [31:0] at;
    res = '0;
    if (head) restart_scan();
    if (sc_phase == PH_DONE) return 1'b0;
    at = sc_pos;
    sc_pos = at + 32'd1;
    case (sc_phase)
      PH_HEADER: begin
        if (at < 32'd4) begin
          if (b != Magic[at[1:0]] || tail) begin
            res = close_scan(ST_BAD_MAGIC, '0, '0);
            return 1'b1;
          end
          return 1'b0;
        end
        if (b < VersionMin || b > VersionMax) begin
          res = close_scan(ST_BAD_VERSION, '0, '0);
          return 1'b1;
        end
        if (tail) begin
          res = close_scan(ST_NOT_FOUND, '0, '0);
          return 1'b1;
        end
        sc_phase = PH_LEN;
      end
      PH_LEN: begin
        if (tail) begin
          res = close_scan(ST_NOT_FOUND, '0, '0);
          return 1'b1;
        end
        if (b == 8'h00 || b > MaxDescriptorLenDef) begin
          res = close_scan(ST_BAD_DESC, '0, '0);
          return 1'b1;
        end
        sc_desc_len = b[6:0];
        sc_idx      = '0;
        sc_hit      = 1'b1;
        sc_nul      = 1'b0;
        sc_phase    = PH_DESC;
      end
      PH_DESC: begin
        if (tail) begin
          res = close_scan(ST_NOT_FOUND, '0, '0);
          return 1'b1;
        end
        // compare as C strings: stop at the first zero byte
        if (!sc_nul) begin
          if (b == 8'h00) begin
            sc_nul = 1'b1;
            if (!tag_stops(sc_idx)) sc_hit = 1'b0;
          end else if (sc_idx >= tag_span() || tag_byte(sc_idx) != b) begin
            sc_hit = 1'b0;
          end
        end
        sc_idx = sc_idx + 7'd1;
        if (sc_idx >= sc_desc_len) begin
          if (!sc_nul && !tag_stops(sc_desc_len)) sc_hit = 1'b0;
          sc_idx   = '0;
          sc_blen  = '0;
          sc_phase = PH_BLEN;
        end
      end
      PH_BLEN: begin
        if (tail) begin
          res = close_scan(ST_NOT_FOUND, '0, '0);
          return 1'b1;
        end
        sc_blen = sc_blen | ({24'd0, b} << {sc_idx[1:0], 3'b000});
        sc_idx = sc_idx + 7'd1;
        if (sc_idx < 7'd4) return 1'b0;
        sc_idx = '0;
        if (sc_hit) begin
          res = close_scan(ST_FOUND, sc_pos, sc_blen);
          return 1'b1;
        end
        sc_skip = sc_blen;
        if (sc_skip == 32'd0) sc_phase = PH_LEN;
        else sc_phase = PH_SKIP;
      end
      PH_SKIP: begin
        if (tail) begin
          res = close_scan(ST_NOT_FOUND, '0, '0);
          return 1'b1;
        end
        sc_skip = sc_skip - 32'd1;
        if (sc_skip == 32'd0) sc_phase = PH_LEN;
      end
      default: sc_phase = PH_DONE;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // File builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] nonzero_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[i * 8 +: 8] = 8'($urandom_range(1, 255));
    return w;
  endfunction

  // append one record: length byte, descriptor, block length, and the block unless it is a match
  function automatic void put_record(int unsigned kind);
    logic [7:0]  d [$];
    logic [31:0] blen;
    int unsigned pad_to;
    int unsigned j;
    case (kind)
      RecMatch: begin
        d = tag_text;
        if (d.size() == 0 || $urandom_range(0, 1) == 1) begin
          pad_to = ($urandom_range(0, 3) == 0) ? 64 : d.size() + $urandom_range(1, 4);
          d.push_back(8'h00);
          while (d.size() < pad_to) d.push_back(rand_byte());
        end
      end
      RecNear: begin
        d = tag_text;
        case ($urandom_range(0, 2))
          0: if (d.size() > 0) begin
            j = $urandom_range(0, d.size() - 1);
            d[j] = d[j] ^ 8'($urandom_range(1, 255));
          end
          1: if (d.size() > 0) void'(d.pop_back());
          default: d.push_back(8'($urandom_range(1, 255)));
        endcase
        if (d.size() == 0) d.push_back(8'($urandom_range(1, 255)));
      end
      RecRandom: begin
        pad_to = $urandom_range(1, 8);
        while (d.size() < pad_to) d.push_back(rand_byte());
      end
      default: begin
        while (d.size() < MaxDescriptorLenDef) d.push_back(rand_byte());
      end
    endcase
    doc.push_back(8'(d.size()));
    foreach (d[k]) doc.push_back(d[k]);
    if (kind == RecMatch) blen = $urandom;
    else if ($urandom_range(0, 19) == 0) blen = $urandom_range(7, 300);
    else blen = $urandom_range(0, 6);
    for (j = 0; j < 4; j++) doc.push_back(blen[j * 8 +: 8]);
    if (kind != RecMatch) begin
      for (j = 0; j < blen; j++) doc.push_back(rand_byte());
    end
  endfunction

  // magic, version and a short chain of records; a match ends the chain
  function automatic void build_doc();
    int unsigned nrec;
    int unsigned pick;
    int unsigned kind;
    doc.delete();
    for (int i = 0; i < 4; i++) doc.push_back(Magic[i]);
    doc.push_back(8'($urandom_range(VersionMin, VersionMax)));
    nrec = $urandom_range(1, 4);
    for (int r = 0; r < nrec; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) kind = RecMatch;
      else if (pick < 50) kind = RecNear;
      else if (pick < 85) kind = RecRandom;
      else kind = RecLong;
      put_record(kind);
      if (kind == RecMatch) begin
        // no trailer now and then, so the last length byte is final
        if ($urandom_range(0, 7) != 0) begin
          pick = $urandom_range(1, 3);
          for (int t = 0; t < pick; t++) doc.push_back(rand_byte());
        end
        break;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // offer one byte request, wait for it to be taken, then predict its result
  task automatic offer_byte(input logic [7:0] b, input bit head, input bit tail,
                            input bit typed, input tcs_result_t typed_res);
    tcs_result_t res;
    bit          got;
    bit          dropped;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= head;
    s_axis_tlast  <= tail;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    dropped = !head && sc_phase == PH_DONE;
    got = predict_scan(b, head, tail, res);
    if (!dropped) live_items++;
    if (typed) pending_reports.push_back(typed_res);
    else if (got) pending_reports.push_back(res);
  endtask

  task automatic send_doc(int unsigned upto);
    for (int unsigned i = 0; i < upto; i++) begin
      offer_byte(doc[i], i == 0, i == upto - 1, 1'b0, '0);
    end
  endtask

  // hold the byte stream until every result is in and the block is quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(tcs_cfg_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TAG_LENGTH: tag_len_q = val[4:0];
      CFG_TAG_FIRST:  tag_words[0] = val;
      CFG_TAG_MIDDLE: tag_words[1] = val;
      default:        tag_words[2] = val;
    endcase
  endtask

  // load a new tag setting; the first few cover the extremes
  task automatic retag(int unsigned k);
    logic [63:0] w [3];
    logic [4:0]  len;
    int unsigned z;
    settle();
    for (int i = 0; i < 3; i++) w[i] = nonzero_word();
    case (k)
      0: len = 5'd24;
      1: len = 5'd0;
      2: len = 5'd31;
      3: len = 5'd1;
      4: begin
        len = 5'd8;
        w[0] = '1;
      end
      5: begin
        len = 5'($urandom_range(2, 24));
        z = $urandom_range(0, len - 1);
        w[z / 8][(z % 8) * 8 +: 8] = 8'h00;
      end
      6: begin
        len = 5'd24;
        for (int i = 0; i < 3; i++) w[i] = '0;
      end
      default: begin
        len = 5'($urandom_range(0, 31));
        for (int i = 0; i < 24; i++) begin
          if ($urandom_range(0, 15) == 0) w[i / 8][(i % 8) * 8 +: 8] = 8'h00;
        end
      end
    endcase
    write_reg(CFG_TAG_LENGTH, {59'($urandom_range(0, 1023)), len});
    write_reg(CFG_TAG_FIRST, w[0]);
    write_reg(CFG_TAG_MIDDLE, w[1]);
    write_reg(CFG_TAG_LAST, w[2]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    tag_text.delete();
    for (int unsigned i = 0; i < tag_span(); i++) begin
      if (tag_byte(i) == 8'h00) break;
      tag_text.push_back(tag_byte(i));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold when asked
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_out = 1'b0;
      end else begin
        m_axis_tready <= steady || $urandom_range(0, 99) >= 10;
      end
    end
  end

  // compare each result request with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_report = tcs_result_t'(m_axis_tdata[ResultW-1:0]);
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result status %0d offset %0d length %0d", $time,
                 seen_report.scan_status, seen_report.data_offset,
                 seen_report.data_length);
        faults++;
      end else begin
        want_report = pending_reports.pop_front();
        if (seen_report.scan_status != want_report.scan_status) begin
          $display("%0t: scan_status expected %0d got %0d", $time,
                   want_report.scan_status, seen_report.scan_status);
          faults++;
        end
        if (seen_report.data_offset != want_report.data_offset) begin
          $display("%0t: data_offset expected %0d got %0d", $time,
                   want_report.data_offset, seen_report.data_offset);
          faults++;
        end
        if (seen_report.data_length != want_report.data_length) begin
          $display("%0t: data_length expected %0d got %0d", $time,
                   want_report.data_length, seen_report.data_length);
          faults++;
        end
      end
    end
  end

  // end the run when no request of any kind moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    tcs_result_t typed_res;
    int unsigned files;
    int unsigned mode;
    int unsigned n;
    logic [7:0]  bad;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_TAG_LENGTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    live_items    = 0;
    faults        = 0;
    idle_cycles   = 0;
    steady        = 1'b0;
    hold_out      = 1'b0;
    tag_len_q     = TagLenReset;
    for (int i = 0; i < 3; i++) tag_words[i] = '0;
    restart_scan();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table under the reset tag
    foreach (Probes[i]) begin
      typed_res.scan_status = Probes[i].status;
      typed_res.data_offset = Probes[i].offset;
      typed_res.data_length = Probes[i].length;
      offer_byte(Probes[i].data, Probes[i].head, Probes[i].tail, Probes[i].typed,
                 typed_res);
    end

    // random files, a new tag every few files
    files = 0;
    while (live_items < 1000) begin
      if (files % 5 == 0) retag(files / 5);
      steady = files >= 5 && files < 9;
      if (files == 3) begin
        // stall the result side while one-byte files pile up
        hold_out = 1'b1;
        for (int i = 0; i < 12; i++) offer_byte(8'h00, 1'b1, $urandom_range(0, 1) == 1,
                                                1'b0, '0);
      end
      build_doc();
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        send_doc(doc.size());
      end else if (mode < 80) begin
        send_doc($urandom_range(1, doc.size()));
      end else if (mode < 85) begin
        doc[$urandom_range(0, doc.size() - 1)] = rand_byte();
        send_doc(doc.size());
      end else if (mode < 90) begin
        bad = rand_byte();
        while (bad >= VersionMin && bad <= VersionMax) bad = rand_byte();
        doc[4] = bad;
        send_doc(doc.size());
      end else if (mode < 95) begin
        doc[5] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(65, 255));
        send_doc(doc.size());
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          offer_byte(rand_byte(), $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                     1'b0, '0);
        end
      end
      files++;
    end
    steady = 1'b0;

    settle();
    if (faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
